// File: hdl/stream_find_replace_defines.svh
// Assertion macros for the stream find-and-replace block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

`ifndef ASSERT_OFF

`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
// Used by the controller, the datapath and the top level; no dependencies.
package sfr_pkg;

  localparam int MAX_WORD   = 8;
  localparam int IDX_W      = $clog2(MAX_WORD);
  localparam int LEN_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = MAX_WORD * BYTE_W;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_WORD    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEARCH_LENGTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACE_WORD   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACE_LENGTH = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              segment_end;
  } sfr_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              line_done;
  } sfr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_REP,
    ST_POP
  } sfr_state_t;

  typedef struct packed {
    logic append;
    logic pop;
    logic rep;
    logic marker;
    logic clear_fill;
    logic clear_cnt;
    logic last;
    logic done;
  } sfr_cmd_t;

  typedef struct packed {
    logic fill_gt;
    logic fill_eq;
    logic match;
    logic rlen_zero;
    logic seg;
    logic fill_one;
    logic rep_last;
    logic out_free;
  } sfr_stat_t;

endpackage

// File: hdl/sfr_datapath.sv
// Window shift register, pattern compare, config registers and output register.
// Depends on sfr_pkg and stream_find_replace_defines.svh.
`include "stream_find_replace_defines.svh"

module sfr_datapath
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]     cfg_wdata,
  input  sfr_in_t               in_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output sfr_out_t              out_data,
  input  sfr_cmd_t              cmd,
  output sfr_stat_t             stat
);

  logic [WORD_W-1:0] search_word_r;
  logic [LEN_W-1:0]  search_length_r;
  logic [WORD_W-1:0] replace_word_r;
  logic [LEN_W-1:0]  replace_length_r;

  logic [BYTE_W-1:0] win_r   [MAX_WORD];
  logic [BYTE_W-1:0] win_nxt [MAX_WORD];
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              seg_r;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  sfr_out_t          out_item_r, out_item_nxt;

  logic [LEN_W-1:0]  slen, rlen;
  logic [MAX_WORD-1:0] byte_hit;
  logic [BYTE_W-1:0] rep_byte;
  logic              out_free;
  logic              emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_word_r    <= '0;
      search_length_r  <= LEN_W'(1);
      replace_word_r   <= '0;
      replace_length_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SEARCH_WORD:    search_word_r    <= cfg_wdata;
        REG_SEARCH_LENGTH:  search_length_r  <= cfg_wdata[LEN_W-1:0];
        REG_REPLACE_WORD:   replace_word_r   <= cfg_wdata;
        REG_REPLACE_LENGTH: replace_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (search_length_r == '0) begin
      slen = LEN_W'(1);
    end else if (search_length_r > LEN_W'(MAX_WORD)) begin
      slen = LEN_W'(MAX_WORD);
    end else begin
      slen = search_length_r;
    end
    rlen = (replace_length_r > LEN_W'(MAX_WORD)) ? LEN_W'(MAX_WORD) : replace_length_r;
  end

  always_comb begin
    for (int i = 0; i < MAX_WORD; i++) begin
      byte_hit[i] = (win_r[i] == search_word_r[i*BYTE_W +: BYTE_W]) || (LEN_W'(i) >= slen);
    end
  end

  assign rep_byte = replace_word_r[{cnt_r, 3'b000} +: BYTE_W];
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd.pop || cmd.rep || cmd.marker;

  always_comb begin
    stat.fill_gt   = fill_r > slen;
    stat.fill_eq   = fill_r == slen;
    stat.match     = &byte_hit;
    stat.rlen_zero = rlen == '0;
    stat.seg       = seg_r;
    stat.fill_one  = fill_r == LEN_W'(1);
    stat.rep_last  = (LEN_W'(cnt_r) + LEN_W'(1)) == rlen;
    stat.out_free  = out_free;
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    if (cmd.append) begin
      win_nxt[fill_r[IDX_W-1:0]] = in_data.in_byte;
      fill_nxt = fill_r + LEN_W'(1);
    end else if (cmd.pop) begin
      for (int i = 0; i < MAX_WORD - 1; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      fill_nxt = fill_r - LEN_W'(1);
    end else if (cmd.clear_fill) begin
      fill_nxt = '0;
    end
    if (cmd.clear_cnt) begin
      cnt_nxt = '0;
    end else if (cmd.rep) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.run_last   = cmd.last;
      out_item_nxt.line_done  = cmd.done;
      out_item_nxt.byte_valid = !cmd.marker;
      if (cmd.pop) begin
        out_item_nxt.out_byte = win_r[0];
      end else if (cmd.rep) begin
        out_item_nxt.out_byte = rep_byte;
      end else begin
        out_item_nxt.out_byte = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_item_r <= out_item_nxt;
    if (cmd.append) begin
      seg_r <= in_data.segment_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `SFR_ASSERT(a_fill_bound, clk, rst_n, fill_r <= LEN_W'(MAX_WORD), "window fill out of range")
  `SFR_ASSERT_IMPL(a_marker_flags, clk, rst_n, out_valid_r && !out_item_r.byte_valid, out_item_r.run_last && out_item_r.line_done, "end marker without last flags")
  `SFR_ASSERT_NEXT(a_pop_dec, clk, rst_n, cmd.pop, fill_r == $past(fill_r) - LEN_W'(1), "pop did not shrink window")

endmodule

// File: hdl/sfr_ctrl.sv
// Sequencer for the stream find-and-replace block: accept, decide, emit.
// Depends on sfr_pkg and stream_find_replace_defines.svh.
`include "stream_find_replace_defines.svh"

module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sfr_stat_t stat,
  output sfr_cmd_t  cmd
);

  sfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = state_r != ST_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.append = 1'b1;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.fill_gt || (stat.fill_eq && !stat.match)) begin
          if (stat.out_free) begin
            cmd.pop   = 1'b1;
            cmd.last  = !stat.seg || stat.fill_one;
            cmd.done  = stat.seg && stat.fill_one;
            state_nxt = (stat.seg && !stat.fill_one) ? ST_POP : ST_IDLE;
          end
        end else if (stat.fill_eq) begin
          if (!stat.rlen_zero) begin
            cmd.clear_fill = 1'b1;
            cmd.clear_cnt  = 1'b1;
            state_nxt      = ST_REP;
          end else if (stat.seg) begin
            if (stat.out_free) begin
              cmd.marker     = 1'b1;
              cmd.clear_fill = 1'b1;
              cmd.last       = 1'b1;
              cmd.done       = 1'b1;
              state_nxt      = ST_IDLE;
            end
          end else begin
            cmd.clear_fill = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          state_nxt = stat.seg ? ST_POP : ST_IDLE;
        end
      end
      ST_REP: begin
        if (stat.out_free) begin
          cmd.rep  = 1'b1;
          cmd.last = stat.rep_last;
          cmd.done = stat.seg && stat.rep_last;
          if (stat.rep_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (stat.out_free) begin
          cmd.pop  = 1'b1;
          cmd.last = stat.fill_one;
          cmd.done = stat.fill_one;
          if (stat.fill_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `SFR_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.pop || cmd.rep || cmd.marker, stat.out_free, "emit while output register busy")
  `SFR_ASSERT_IMPL(a_flush_seg, clk, rst_n, state_r == ST_POP, stat.seg, "flush without segment end")
  `SFR_ASSERT_IMPL(a_done_last, clk, rst_n, cmd.done, cmd.last, "line end not marked last")

endmodule

// File: hdl/stream_find_replace.sv
// Stream find-and-replace: replaces leftmost non-overlapping pattern matches.
// A result is registered from the decide state, or from the replacement or flush state when the
// decide state emits nothing (replacement burst, flush of a window shorter than the pattern).
// No new item is taken until the accept/decide sequencer is back in idle and the item's results,
// if any, have entered the one output register; out_stall holds the sequencer longer.
// Reset (rst_n low, synchronous): empty window, search length 1, other config registers 0.
module stream_find_replace
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [WORD_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sfr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sfr_out_t              out_data
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: tb/stream_find_replace_tb.sv
// Self-checking testbench for stream_find_replace: directed and random text streams.
// The scoreboard class predicts the find-and-replace output from its own copy of the window.
// Depends on sfr_pkg and the stream_find_replace RTL only.
module stream_find_replace_tb
  import sfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_ITEMS    = 49;
  localparam int MAX_PRINTS     = 200;

  class sfr_scoreboard;
    logic [WORD_W-1:0] search_word;
    logic [WORD_W-1:0] replace_word;
    logic [LEN_W-1:0]  search_len_reg;
    logic [LEN_W-1:0]  replace_len_reg;
    logic [BYTE_W-1:0] window [MAX_WORD];
    int unsigned       fill;
    sfr_out_t          run_buf [MAX_WORD];
    int unsigned       run_n;
    sfr_out_t          expected_q [$];
    int unsigned       mismatches;
    int unsigned       prints;

    function void reset_state();
      search_word     = '0;
      replace_word    = '0;
      search_len_reg  = 4'd1;
      replace_len_reg = '0;
      fill            = 0;
      mismatches      = 0;
      prints          = 0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [WORD_W-1:0] value);
      case (idx)
        REG_SEARCH_WORD:    search_word     = value;
        REG_SEARCH_LENGTH:  search_len_reg  = value[LEN_W-1:0];
        REG_REPLACE_WORD:   replace_word    = value;
        REG_REPLACE_LENGTH: replace_len_reg = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void emit_byte(logic [BYTE_W-1:0] b, logic valid);
      sfr_out_t r;
      if (run_n >= MAX_WORD) return;
      r.out_byte   = b;
      r.byte_valid = valid;
      r.run_last   = 1'b0;
      r.line_done  = 1'b0;
      run_buf[run_n] = r;
      run_n++;
    endfunction

    function void pop_oldest();
      if (fill == 0) return;
      emit_byte(window[0], 1'b1);
      for (int i = 1; i < fill && i < MAX_WORD; i++) window[i-1] = window[i];
      fill--;
    endfunction

    function void note_input(sfr_in_t item);
      int unsigned slen;
      int unsigned rlen;
      bit          hit;
      slen  = (search_len_reg == 0) ? 1 :
              (search_len_reg > MAX_WORD) ? MAX_WORD : search_len_reg;
      rlen  = (replace_len_reg > MAX_WORD) ? MAX_WORD : replace_len_reg;
      run_n = 0;
      if (fill >= MAX_WORD) fill = MAX_WORD - 1;
      window[fill] = item.in_byte;
      fill++;
      if (fill > slen) begin
        pop_oldest();
      end else if (fill == slen) begin
        hit = 1'b1;
        for (int i = 0; i < slen; i++)
          if (window[i] != search_word[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++) emit_byte(replace_word[8*i +: 8], 1'b1);
          fill = 0;
        end else begin
          pop_oldest();
        end
      end
      if (item.segment_end) begin
        while (fill > 0 && run_n < MAX_WORD) pop_oldest();
        fill = 0;
        if (run_n == 0) emit_byte('0, 1'b0);
        run_buf[run_n-1].line_done = 1'b1;
      end
      if (run_n > 0) run_buf[run_n-1].run_last = 1'b1;
      for (int i = 0; i < run_n; i++) expected_q.push_back(run_buf[i]);
    endfunction

    function void check_result(sfr_out_t got);
      sfr_out_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (prints < MAX_PRINTS)
          $display("%0t: expected none, got byte=%h valid=%b last=%b done=%b", $time,
                   got.out_byte, got.byte_valid, got.run_last, got.line_done);
        prints++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
          got.run_last !== exp.run_last || got.line_done !== exp.line_done) begin
        mismatches++;
        if (prints < MAX_PRINTS)
          $display({"%0t: mismatch expected byte=%h valid=%b last=%b done=%b,",
                    " got byte=%h valid=%b last=%b done=%b"},
                   $time, exp.out_byte, exp.byte_valid, exp.run_last, exp.line_done,
                   got.out_byte, got.byte_valid, got.run_last, got.line_done);
        prints++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [WORD_W-1:0]     cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sfr_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sfr_out_t              out_data;

  sfr_scoreboard     sb;
  bit                no_idle  = 1'b0;
  bit                hold_req = 1'b0;
  int unsigned       idle_cycles = 0;
  logic [BYTE_W-1:0] text_q [$];

  stream_find_replace uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic seg);
    int      gap;
    sfr_in_t d;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    d.in_byte     = b;
    d.segment_end = seg;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    sb.note_input(d);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [WORD_W-1:0] sw, input logic [LEN_W-1:0] sl,
                            input logic [WORD_W-1:0] rw, input logic [LEN_W-1:0] rl);
    logic [CFG_ADDR_W-1:0] idx [4];
    logic [WORD_W-1:0]     val [4];
    idx[0] = REG_SEARCH_WORD;
    idx[1] = REG_SEARCH_LENGTH;
    idx[2] = REG_REPLACE_WORD;
    idx[3] = REG_REPLACE_LENGTH;
    val[0] = sw;
    val[1] = {$urandom, 28'($urandom), sl};
    val[2] = rw;
    val[3] = {$urandom, 28'($urandom), rl};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver: random stall per item, one long hold-off on request
  initial begin : result_sink
    int k;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      k = no_idle ? 0 : $urandom_range(0, 5);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : text_source
    logic [WORD_W-1:0] sw;
    logic [WORD_W-1:0] rw;
    logic [LEN_W-1:0]  sl;
    logic [LEN_W-1:0]  rl;
    int unsigned       eff;
    int unsigned       r;
    int unsigned       cnt;
    logic              seg;
    sb = new;
    sb.reset_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one-byte pattern 00, empty replacement
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h41, 1'b1);

    // three-byte pattern, saturated eight-byte replacement
    quiesce();
    set_config(64'h0000_0000_0063_6261, 4'd3, 64'h8899_aabb_ccdd_eeff, 4'd15);
    send_item(8'h78, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b1);

    // fill a long window, then shrink the pattern below the window
    quiesce();
    set_config(64'h0102_0304_0506_0708, 4'd8, 64'h0, 4'd0);
    send_item(8'h08, 1'b0);
    send_item(8'h07, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5a, 1'b0);
    quiesce();
    set_config(64'h0000_0000_0000_00ff, 4'd0, 64'hffff_ffff_ffff_ffff, 4'd1);
    send_item(8'hff, 1'b0);
    send_item(8'ha5, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h01, 1'b1);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin sl = 4'd1;  rl = 4'd0;  end
        1: begin sl = 4'd8;  rl = 4'd8;  end
        2: begin sl = 4'd15; rl = 4'd15; end
        3: begin sl = 4'd0;  rl = 4'd3;  end
        default: begin
          sl = LEN_W'($urandom_range(0, 15));
          rl = LEN_W'($urandom_range(0, 15));
        end
      endcase
      sw = (p == 4) ? '1 : (p == 6) ? '0 : {$urandom, $urandom};
      rw = {$urandom, $urandom};
      eff = (sl == 0) ? 1 : (sl > MAX_WORD) ? MAX_WORD : sl;
      quiesce();
      set_config(sw, sl, rw, rl);
      text_q.delete();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = (i < 12);
        if (p == 2 && i == 10) hold_req = 1'b1;
        if (p == 5 && i == 25) quiesce();
        if (text_q.size() == 0) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            for (int k = 0; k < eff; k++) text_q.push_back(sw[8*k +: 8]);
          end else if (r < 55) begin
            cnt = $urandom_range(1, eff);
            for (int k = 0; k < cnt; k++) text_q.push_back(sw[8*k +: 8]);
          end else begin
            cnt = $urandom_range(1, 3);
            for (int k = 0; k < cnt; k++)
              if ($urandom_range(0, 1))
                text_q.push_back(sw[8*$urandom_range(0, eff-1) +: 8]);
              else
                text_q.push_back(BYTE_W'($urandom_range(0, 255)));
          end
        end
        seg = ($urandom_range(0, 9) == 0) || (p == 7 && i == PHASE_ITEMS - 1);
        send_item(text_q.pop_front(), seg);
      end
    end

    no_idle = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/sfr_pkg.sv
hdl/sfr_datapath.sv
hdl/sfr_ctrl.sv
hdl/stream_find_replace.sv
tb/stream_find_replace_tb.sv
